// File: design/fcdap_pkg.sv
package fcdap_pkg;

   // opcodes
   localparam logic OP_HOST = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [1:0] STATUS_MANUAL = 2'd0;

   localparam logic [9:0] FULL_SCALE = 10'd1023;

   // fader law <-> VCA segments
   localparam logic [9:0]  FWD_BREAK = 10'd157;
   localparam logic [11:0] FWD_LO    = 12'd3677;
   localparam logic [11:0] FWD_HI    = 12'd515;
   localparam logic [9:0]  INV_BREAK = 10'd577;
   localparam logic [11:0] INV_LO    = 12'd271;
   localparam logic [11:0] INV_HI    = 12'd1942;

   // /1000 done as >>3 then multiply by ceil(2^24/125) >> 24, exact below 2^20
   localparam int unsigned LAW_DIV     = 1000;
   localparam int unsigned RECIP_SHIFT = 24;
   localparam logic [17:0] RECIP_MUL   =
      18'(((1 << RECIP_SHIFT) + (LAW_DIV >> 3) - 1) / (LAW_DIV >> 3));

   typedef struct packed {
      logic load_prod;
      logic load_quot;
   } law_ctl_type;

   typedef struct packed {
      logic [9:0] last_dac;
      logic [9:0] target;
      logic [9:0] smooth;
   } state_word_type;

   typedef struct packed {
      logic       opcode;
      logic [2:0] channel;
      logic       in_range;
      logic [1:0] status;
      logic [9:0] sample;
      logic       mute_pin;
      logic       check_mute;
   } item_type;

   typedef struct packed {
      logic        is_host;
      logic        in_range;
      logic [15:0] dac_word;
      logic        press;
      logic        release_flag;
   } result_type;

endpackage

// File: design/fcdap_ram.sv
module fcdap_ram #(
   parameter int unsigned WIDTH = 30,
   parameter int unsigned DEPTH = 8,
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: design/fcdap_law.sv
module fcdap_law
   import fcdap_pkg::*;
#(
   parameter bit INVERSE = 1'b0
) (
   input  logic        clock,
   input  law_ctl_type ctl,
   input  logic [9:0]  x_level,
   output logic [9:0]  y_level
);

   localparam logic [9:0]  BREAK   = INVERSE ? INV_BREAK : FWD_BREAK;
   localparam logic [11:0] COEF_LO = INVERSE ? INV_LO : FWD_LO;
   localparam logic [11:0] COEF_HI = INVERSE ? INV_HI : FWD_HI;
   localparam logic [9:0]  OFFSET  = INVERSE ? FWD_BREAK : INV_BREAK;

   logic        seg;
   logic [9:0]  base;
   logic [11:0] coef;
   logic [21:0] prod_full;
   logic [19:0] prod_ff;
   logic        seg_ff;
   logic [34:0] quot_full;
   logic [9:0]  quot_ff;
   logic        seg2_ff;

   assign seg       = (x_level >= BREAK);
   assign base      = seg ? (x_level - BREAK) : x_level;
   assign coef      = seg ? COEF_HI : COEF_LO;
   assign prod_full = base * coef;
   assign quot_full = prod_ff[19:3] * RECIP_MUL;

   always_ff @(posedge clock) begin
      if (ctl.load_prod) begin
         prod_ff <= prod_full[19:0];
         seg_ff  <= seg;
      end
      if (ctl.load_quot) begin
         quot_ff <= quot_full[33:24];
         seg2_ff <= seg_ff;
      end
   end

   assign y_level = quot_ff + (seg2_ff ? OFFSET : 10'd0);

endmodule

// File: design/fader_channel_dac_adc_processor_unit.sv
// Fader channel datapath. One item is taken per clock cycle, back to back,
// and its result is offered on rsp once the item has passed two stages of
// the host-level law, the state read-modify-write stage and two stages of
// the readback law into the output register. Per-channel smoothed level,
// target and last DAC value share one RAM word; it is read as the item
// enters the update stage, and a one-entry bypass of the last write covers
// back-to-back items on the same channel. Entries read as zero until first
// written, so no clearing pass runs after reset.
// Backpressure on rsp stalls the pipe only once every stage is occupied.
module fader_channel_dac_adc_processor_unit
   import fcdap_pkg::*;
#(
   parameter int unsigned CHANNELS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] channel, [12:3] host_level, [14:13] fader_status, [24:15] adc_sample,
   // [25] mute_pin, [26] check_mute, [31:27] zero
   input  logic [31:0] req_tdata,
   // [0] opcode
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] dac_word, [25:16] readback_level, [26] press flag, [27] release flag,
   // [31:28] zero
   output logic [31:0] rsp_tdata
);

   localparam int unsigned ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // handshake / stage control
   logic accept;
   logic adv1, adv2, adv3, adv4, adv5;
   logic free1, free2, free3, free4, free5, out_free;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, out_valid_ff;

   item_type   req_item;
   item_type   s1_ff, s2_ff, s3_ff;
   logic [9:0] s3_target_ff;
   result_type s3_res;
   result_type s4_ff, s5_ff;

   law_ctl_type fwd_ctl, inv_ctl;
   logic [9:0]  fwd_y, inv_y;

   // state
   logic [CHANNELS-1:0] valid_ff;
   logic [CHANNELS-1:0] mute_ff;
   logic                lw_valid_ff;
   logic [ADDR_W-1:0]   lw_addr_ff;
   state_word_type      lw_data_ff;

   logic [ADDR_W-1:0] rd_addr, a2, a3;
   logic [29:0]       rd_data;
   logic              wr_en;
   state_word_type    ram_word, cur, new_word;

   logic        is_tick;
   logic [11:0] smooth_sum;
   logic [9:0]  smooth_new;
   logic [10:0] avg_sum;
   logic [9:0]  avg, value;
   logic [3:0]  dac_addr;
   logic        mute_change;

   logic [31:0] out_data_ff;

   // ---------------------------------------------------------------- stalls
   assign out_free = !out_valid_ff || rsp_tready;
   assign adv5  = v5_ff && out_free;
   assign free5 = !v5_ff || adv5;
   assign adv4  = v4_ff && free5;
   assign free4 = !v4_ff || adv4;
   assign adv3  = v3_ff && free4;
   assign free3 = !v3_ff || adv3;
   assign adv2  = v2_ff && free3;
   assign free2 = !v2_ff || adv2;
   assign adv1  = v1_ff && free2;
   assign free1 = !v1_ff || adv1;

   assign req_tready = free1;
   assign accept     = req_tvalid && free1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= accept || (v1_ff && !adv1);
         v2_ff        <= adv1 || (v2_ff && !adv2);
         v3_ff        <= adv2 || (v3_ff && !adv3);
         v4_ff        <= adv3 || (v4_ff && !adv4);
         v5_ff        <= adv4 || (v5_ff && !adv5);
         out_valid_ff <= adv5 || (out_valid_ff && !rsp_tready);
      end
   end

   // ---------------------------------------------------------------- intake
   always_comb begin
      req_item.opcode     = req_tuser;
      req_item.channel    = req_tdata[2:0];
      req_item.in_range   = (32'(req_tdata[2:0]) < CHANNELS);
      req_item.status     = req_tdata[14:13];
      req_item.sample     = req_tdata[24:15];
      req_item.mute_pin   = req_tdata[25];
      req_item.check_mute = req_tdata[26];
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= req_item;
      end
      if (adv1) begin
         s2_ff <= s1_ff;
      end
      if (adv2) begin
         s3_ff        <= s2_ff;
         s3_target_ff <= FULL_SCALE - fwd_y;
      end
   end

   // host level to VCA law, runs alongside stages 1 and 2
   assign fwd_ctl.load_prod = accept;
   assign fwd_ctl.load_quot = adv1;

   fcdap_law #(
      .INVERSE (1'b0)
   ) u_fwd_law (
      .clock   (clock),
      .ctl     (fwd_ctl),
      .x_level (req_tdata[12:3]),
      .y_level (fwd_y)
   );

   // ---------------------------------------------------------------- state RMW
   assign a2 = ADDR_W'(s2_ff.channel);
   assign a3 = ADDR_W'(s3_ff.channel);

   // re-read the held item while stage 3 is stalled
   assign rd_addr = adv2 ? a2 : a3;

   fcdap_ram #(
      .WIDTH ($bits(state_word_type)),
      .DEPTH (CHANNELS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (a3),
      .wr_data (new_word),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      ram_word = valid_ff[a3] ? state_word_type'(rd_data) : '0;
      cur      = (lw_valid_ff && (lw_addr_ff == a3)) ? lw_data_ff : ram_word;

      is_tick    = (s3_ff.opcode == OP_TICK);
      // 1023 - sample is the bitwise inverse for a 10-bit sample
      smooth_sum = {2'b00, ~s3_ff.sample} + {1'b0, cur.smooth, 1'b0} + {2'b00, cur.smooth};
      smooth_new = smooth_sum[11:2];
      avg_sum    = {1'b0, cur.target} + {1'b0, cur.last_dac};
      avg        = avg_sum[10:1];
      value      = (s3_ff.status == STATUS_MANUAL) ? s3_ff.sample : avg;
      dac_addr   = {1'b0, s3_ff.channel} + 4'd1;

      if (is_tick) begin
         new_word.last_dac = (s3_ff.status == STATUS_MANUAL) ? cur.last_dac : avg;
         new_word.target   = cur.target;
         new_word.smooth   = smooth_new;
      end else begin
         new_word.last_dac = cur.last_dac;
         new_word.target   = s3_target_ff;
         new_word.smooth   = cur.smooth;
      end

      mute_change = is_tick && s3_ff.in_range && s3_ff.check_mute
                    && (mute_ff[a3] != s3_ff.mute_pin);

      s3_res.is_host      = !is_tick;
      s3_res.in_range     = s3_ff.in_range;
      s3_res.dac_word     = (is_tick && s3_ff.in_range) ? {dac_addr, value, 2'b00} : 16'd0;
      s3_res.press        = mute_change && s3_ff.mute_pin;
      s3_res.release_flag = mute_change && !s3_ff.mute_pin;
   end

   assign wr_en = adv3 && s3_ff.in_range;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         mute_ff     <= '0;
         lw_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[a3] <= 1'b1;
            lw_valid_ff  <= 1'b1;
         end
         if (adv3 && mute_change) begin
            mute_ff[a3] <= s3_ff.mute_pin;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         lw_addr_ff <= a3;
         lw_data_ff <= new_word;
      end
   end

   // ---------------------------------------------------------------- readback
   assign inv_ctl.load_prod = adv3;
   assign inv_ctl.load_quot = adv4;

   fcdap_law #(
      .INVERSE (1'b1)
   ) u_inv_law (
      .clock   (clock),
      .ctl     (inv_ctl),
      .x_level (cur.smooth),
      .y_level (inv_y)
   );

   always_ff @(posedge clock) begin
      if (adv3) begin
         s4_ff <= s3_res;
      end
      if (adv4) begin
         s5_ff <= s4_ff;
      end
      if (adv5) begin
         out_data_ff <= {4'd0, s5_ff.release_flag, s5_ff.press,
                         (s5_ff.is_host && s5_ff.in_range) ? inv_y : 10'd0,
                         s5_ff.dac_word};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

`ifndef ASSERT_OFF
   a_no_write_out_of_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (v3_ff && s3_ff.in_range))
      else $error("state write for a channel outside the configured range");

   a_bypass_tracks_write: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (lw_valid_ff && (lw_data_ff == $past(new_word))))
      else $error("write bypass does not hold the last written word");

   a_host_result_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[25:16] != 10'd0))
         |-> (rsp_tdata[15:0] == 16'd0 && rsp_tdata[27:26] == 2'b00))
      else $error("host update result carries DAC or mute data");

   a_mute_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[26] && rsp_tdata[27]))
      else $error("mute press and release flagged together");
`endif

endmodule

// File: tb/sv/fader_channel_checker.sv
module fader_channel_checker
   import fcdap_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   output int          fail_count,
   output int          pending
);

   localparam int NUM_CH = 8;

   typedef struct packed {
      logic        off_edge;
      logic        on_edge;
      logic [9:0]  readback;
      logic [15:0] dac_word;
   } fader_result_t;

   logic [9:0] smooth_mem   [NUM_CH];
   logic [9:0] target_mem   [NUM_CH];
   logic [9:0] last_dac_mem [NUM_CH];
   logic [7:0] mute_state;

   fader_result_t fader_results_q[$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   function automatic int law_to_vca(input int p);
      if (p < 157) return p * 3677 / 1000;
      return (p - 157) * 515 / 1000 + 577;
   endfunction

   function automatic int vca_to_law(input int v);
      if (v < 577) return v * 271 / 1000;
      return (v - 577) * 1942 / 1000 + 157;
   endfunction

   // updates the per-channel state and returns what the block should answer
   function automatic fader_result_t service_channel(input logic opcode, input logic [31:0] d);
      logic [2:0]    ch;
      logic [9:0]    host;
      logic [1:0]    status;
      logic [9:0]    sample;
      logic          pin;
      logic          chk;
      int            acc;
      logic [9:0]    value;
      fader_result_t res;
      ch     = d[2:0];
      host   = d[12:3];
      status = d[14:13];
      sample = d[24:15];
      pin    = d[25];
      chk    = d[26];
      res    = '0;
      if (opcode == OP_HOST) begin
         acc = 1023 - law_to_vca(int'(host));
         target_mem[ch] = acc[9:0];
         acc = vca_to_law(int'(smooth_mem[ch]));
         res.readback = acc[9:0];
      end else begin
         if (chk && mute_state[ch] != pin) begin
            res.on_edge    = pin;
            res.off_edge   = !pin;
            mute_state[ch] = pin;
         end
         acc = (1023 - int'(sample) + 3 * int'(smooth_mem[ch])) / 4;
         smooth_mem[ch] = acc[9:0];
         if (status == STATUS_MANUAL) begin
            value = sample;
         end else begin
            acc = (int'(target_mem[ch]) + int'(last_dac_mem[ch])) / 2;
            value = acc[9:0];
            last_dac_mem[ch] = value;
         end
         res.dac_word = {4'd1 + ch, value, 2'b00};
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      fader_result_t want;
      if (reset) begin
         for (int i = 0; i < NUM_CH; i++) begin
            smooth_mem[i]   = '0;
            target_mem[i]   = '0;
            last_dac_mem[i] = '0;
         end
         mute_state = '0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (fader_results_q.size() == 0) begin
               report_mismatch("unexpected result transfer", int'(rsp_tdata), 0);
            end else begin
               want = fader_results_q.pop_front();
               if (rsp_tdata[15:0] !== want.dac_word)
                  report_mismatch("dac_word", int'(rsp_tdata[15:0]), int'(want.dac_word));
               if (rsp_tdata[25:16] !== want.readback)
                  report_mismatch("readback_level", int'(rsp_tdata[25:16]), int'(want.readback));
               if (rsp_tdata[26] !== want.on_edge)
                  report_mismatch("press flag", int'(rsp_tdata[26]), int'(want.on_edge));
               if (rsp_tdata[27] !== want.off_edge)
                  report_mismatch("release flag", int'(rsp_tdata[27]), int'(want.off_edge));
            end
         end
         if (req_tvalid && req_tready)
            fader_results_q.push_back(service_channel(req_tuser, req_tdata));
      end
      pending = fader_results_q.size();
   end

endmodule

// File: tb/sv/tb_fader_channel_dac_adc_processor_unit.sv
module tb_fader_channel_dac_adc_processor_unit;
   import fcdap_pkg::*;

   localparam logic [1:0] STATUS_AUTO  = 2'd1;
   localparam logic [1:0] STATUS_TOUCH = 2'd2;
   localparam logic [1:0] STATUS_WRITE = 2'd3;
   localparam int NUM_RANDOM = 1600;
   localparam int MAX_IDLE   = 17;
   localparam int DRAIN_CYCLES = 20;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   int   fail_count;
   int   pending;
   logic send_burst = 1'b0;
   logic take_burst = 1'b0;
   int   host_items = 0;
   int   tick_items = 0;
   int   tick_auto_items = 0;

   fader_channel_dac_adc_processor_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   fader_channel_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   task automatic send_item(input logic op, input logic [2:0] ch, input logic [9:0] host,
                            input logic [1:0] status, input logic [9:0] sample,
                            input logic pin, input logic chk);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {5'b0, chk, pin, sample, status, host, ch};
      do @(posedge clock); while (!req_tready);
      if (op == OP_HOST) begin
         host_items++;
      end else begin
         tick_items++;
         if (status != STATUS_MANUAL) tick_auto_items++;
      end
   endtask

   task automatic host_update(input logic [2:0] ch, input logic [9:0] host);
      send_item(OP_HOST, ch, host, 2'($urandom), 10'($urandom), 1'($urandom), 1'($urandom));
   endtask

   task automatic tick(input logic [2:0] ch, input logic [1:0] status, input logic [9:0] sample,
                       input logic pin, input logic chk);
      send_item(OP_TICK, ch, 10'($urandom), status, sample, pin, chk);
   endtask

   // result side: per-result stall, with stall-free stretches now and then
   initial begin
      int stall;
      repeat (2) @(posedge clock);
      forever begin
         if ($urandom_range(0, 63) == 0) take_burst = !take_burst;
         stall = take_burst ? 0 : $urandom_range(0, MAX_IDLE);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin
      logic [2:0] ch;
      logic [2:0] prev_ch;
      logic [9:0] host;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // readback before any tick, then both law segments and their edges
      host_update(3'd0, 10'd0);
      host_update(3'd7, 10'd1023);
      host_update(3'd1, 10'd156);
      host_update(3'd2, 10'd157);
      host_update(3'd3, 10'd577);
      // an extreme of the sample in every status, then a midscale sample
      tick(3'd0, STATUS_MANUAL, 10'd0, 1'b0, 1'b0);
      tick(3'd7, STATUS_AUTO, 10'd1023, 1'b0, 1'b0);
      tick(3'd1, STATUS_TOUCH, 10'd0, 1'b0, 1'b0);
      tick(3'd2, STATUS_WRITE, 10'd1023, 1'b0, 1'b0);
      tick(3'd3, STATUS_AUTO, 10'd512, 1'b0, 1'b0);
      // mute: press, held, check off with pin low, release
      tick(3'd4, STATUS_MANUAL, 10'd100, 1'b1, 1'b1);
      tick(3'd4, STATUS_MANUAL, 10'd100, 1'b1, 1'b1);
      tick(3'd4, STATUS_AUTO, 10'd200, 1'b0, 1'b0);
      tick(3'd4, STATUS_AUTO, 10'd300, 1'b0, 1'b1);
      tick(3'd4, STATUS_WRITE, 10'd300, 1'b0, 1'b1);
      // smoothed level read back after ticks, wide and narrow
      host_update(3'd7, 10'd500);
      host_update(3'd0, 10'd1023);
      host_update(3'd4, 10'd0);
      tick(3'd7, STATUS_AUTO, 10'd0, 1'b1, 1'b1);
      tick(3'd7, STATUS_AUTO, 10'd0, 1'b0, 1'b1);

      prev_ch = '0;
      for (int i = 0; i < NUM_RANDOM; i++) begin
         if ($urandom_range(0, 49) == 0) send_burst = !send_burst;
         // repeat the channel often so updates land back to back on one entry
         ch = ($urandom_range(0, 3) == 0) ? prev_ch : 3'($urandom);
         prev_ch = ch;
         if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 7))
               0: host = 10'($urandom_range(150, 164));
               1: host = ($urandom_range(0, 1) == 0) ? 10'd0 : 10'd1023;
               default: host = 10'($urandom);
            endcase
            host_update(ch, host);
         end else begin
            tick(ch, 2'($urandom), 10'($urandom), 1'($urandom),
                 ($urandom_range(0, 3) != 0));
         end
      end
      req_tvalid <= 1'b0;

      // let the checker count the last transfer before looking at pending
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d host updates and %0d ticks (%0d with automation active)",
               host_items, tick_items, tick_auto_items);
      if (fail_count == 0)
         $display("fader_channel_dac_adc_processor_unit regression: pass");
      else
         $display("fader_channel_dac_adc_processor_unit regression: fail");
      $finish;
   end

   initial begin
      #4000000;
      $display("timeout with %0d results outstanding", pending);
      $display("fader_channel_dac_adc_processor_unit regression: fail");
      $finish;
   end

endmodule

// File: filelist.f
design/fcdap_pkg.sv
design/fcdap_ram.sv
design/fcdap_law.sv
design/fader_channel_dac_adc_processor_unit.sv
tb/sv/fader_channel_checker.sv
tb/sv/tb_fader_channel_dac_adc_processor_unit.sv
